// ===== hdl/rycc_pkg.sv =====
// Shared types and fixed-point constants for the RGB/YUV colour space converter.
`default_nettype none

package rycc_pkg;

    // Fixed-point format of the coefficients.
    localparam int FRACTION_BITS = 14;
    localparam int COEF_W        = FRACTION_BITS + 2;
    localparam int PIX_W         = 8;
    localparam int OPND_W        = PIX_W + 1;
    localparam int PROD_W        = OPND_W + COEF_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int INT_W         = SUM_W - FRACTION_BITS;

    localparam longint ONE_FIX   = longint'(1) << FRACTION_BITS;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // Coefficients, rounded half up from ten-thousandths.
    localparam coef_t C_ONE    = coef_t'(ONE_FIX);
    localparam coef_t C_Y_R    = coef_t'((longint'(2990)  * ONE_FIX + 5000) / 10000);
    localparam coef_t C_Y_G    = coef_t'((longint'(5870)  * ONE_FIX + 5000) / 10000);
    localparam coef_t C_Y_B    = coef_t'((longint'(1140)  * ONE_FIX + 5000) / 10000);
    localparam coef_t C_U_R    = coef_t'((longint'(1690)  * ONE_FIX + 5000) / 10000);
    localparam coef_t C_U_G    = coef_t'((longint'(3310)  * ONE_FIX + 5000) / 10000);
    localparam coef_t C_U_B    = coef_t'((longint'(4990)  * ONE_FIX + 5000) / 10000);
    localparam coef_t C_V_R    = coef_t'((longint'(4990)  * ONE_FIX + 5000) / 10000);
    localparam coef_t C_V_G    = coef_t'((longint'(4180)  * ONE_FIX + 5000) / 10000);
    localparam coef_t C_V_B    = coef_t'((longint'(813)   * ONE_FIX + 5000) / 10000);
    localparam coef_t C_R_V    = coef_t'((longint'(14020) * ONE_FIX + 5000) / 10000);
    localparam coef_t C_G_U    = coef_t'((longint'(3440)  * ONE_FIX + 5000) / 10000);
    localparam coef_t C_G_V    = coef_t'((longint'(7140)  * ONE_FIX + 5000) / 10000);
    localparam coef_t C_B_U    = coef_t'((longint'(17720) * ONE_FIX + 5000) / 10000);

    // Chroma offset of 128 in the accumulator's fixed-point format.
    localparam sum_t HALF_FIX  = sum_t'(longint'(128) * ONE_FIX);

    // Register indexes of the configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_FIRST = 2'd1;

    // Conversion directions.
    localparam logic DIR_RGB_TO_YUV = 1'b0;
    localparam logic DIR_YUV_TO_RGB = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] first_in;
        logic [PIX_W-1:0] second_in;
        logic [PIX_W-1:0] third_in;
        logic             last_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] first_out;
        logic [PIX_W-1:0] second_out;
        logic [PIX_W-1:0] third_out;
        logic             last_out;
    } pixel_out_t;

endpackage

`default_nettype wire

// ===== hdl/rgb_yuv_color_space_converter_unit.sv =====
// Top level of the pipelined RGB/YUV colour space converter.
`default_nettype none

// One pixel enters per clock when the output side does not stall, and the four
// register stages that its conversion passes through are
// operand selection, the nine coefficient multiplications, the three weighted
// sums and the floor-and-clip with output ordering, and the multiply stage sets
// the clock period. A stall at the output fills empty stages first and only then
// holds the input. Direction and blue_first are read when an item enters and
// travel with it, and should be written only while no item is in flight.
module rgb_yuv_color_space_converter_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire rycc_pkg::pixel_in_t               in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output rycc_pkg::pixel_out_t                   out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rycc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic                              cfg_data
);
    import rycc_pkg::*;

    logic       direction_reg;
    logic       blue_first_reg;

    logic       s1_valid_reg;
    opnd_t      s1_opnd_reg [3];
    logic       s1_dir_reg;
    logic       s1_bf_reg;
    logic       s1_last_reg;

    logic       s2_valid_reg;
    prod_t      s2_prod_reg [3][3];
    logic       s2_dir_reg;
    logic       s2_bf_reg;
    logic       s2_last_reg;

    logic       s3_valid_reg;
    sum_t       s3_sum_reg [3];
    logic       s3_dir_reg;
    logic       s3_bf_reg;
    logic       s3_last_reg;

    logic       s4_valid_reg;
    pixel_out_t s4_data_reg;

    logic       rdy1, rdy2, rdy3, rdy4;
    opnd_t      s1_opnd_next [3];
    coef_t      coef_mat [3][3];
    prod_t      s2_prod_next [3][3];
    sum_t       s3_sum_next [3];
    logic [PIX_W-1:0] clip_val [3];
    pixel_out_t s4_data_next;

    // Floors a fixed-point sum and clips it to the pixel range.
    function automatic logic [PIX_W-1:0] floor_clip(input sum_t acc);
        logic signed [INT_W-1:0] ip;
        ip = acc[SUM_W-1:FRACTION_BITS];
        if (ip < 0)
            floor_clip = '0;
        else if (ip > 255)
            floor_clip = '1;
        else
            floor_clip = ip[PIX_W-1:0];
    endfunction

    // A stage may load when it is empty or its contents move on.
    assign rdy4      = !s4_valid_reg || !out_stall;
    assign rdy3      = !s3_valid_reg || rdy4;
    assign rdy2      = !s2_valid_reg || rdy3;
    assign rdy1      = !s1_valid_reg || rdy2;
    assign in_stall  = !rdy1;
    assign out_valid = s4_valid_reg;
    assign out_data  = s4_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg  <= DIR_RGB_TO_YUV;
            blue_first_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DIRECTION:  direction_reg  <= cfg_data;
                REG_BLUE_FIRST: blue_first_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Stage 1: operands. In reverse mode the chroma inputs are centred on zero.
    always_comb
    begin
        s1_opnd_next[0] = opnd_t'({1'b0, in_data.first_in});
        if (direction_reg == DIR_YUV_TO_RGB)
        begin
            s1_opnd_next[1] = opnd_t'({1'b0, in_data.second_in}) - opnd_t'(128);
            s1_opnd_next[2] = opnd_t'({1'b0, in_data.third_in}) - opnd_t'(128);
        end
        else
        begin
            s1_opnd_next[1] = opnd_t'({1'b0, in_data.second_in});
            s1_opnd_next[2] = opnd_t'({1'b0, in_data.third_in});
        end
    end

    // Stage 2: coefficient matrix by direction, then nine products.
    always_comb
    begin
        case (s1_dir_reg)
            DIR_RGB_TO_YUV:
            begin
                coef_mat[0][0] = C_Y_R;
                coef_mat[0][1] = C_Y_G;
                coef_mat[0][2] = C_Y_B;
                coef_mat[1][0] = -C_U_R;
                coef_mat[1][1] = -C_U_G;
                coef_mat[1][2] = C_U_B;
                coef_mat[2][0] = C_V_R;
                coef_mat[2][1] = -C_V_G;
                coef_mat[2][2] = -C_V_B;
            end
            default:
            begin
                coef_mat[0][0] = C_ONE;
                coef_mat[0][1] = '0;
                coef_mat[0][2] = C_R_V;
                coef_mat[1][0] = C_ONE;
                coef_mat[1][1] = -C_G_U;
                coef_mat[1][2] = -C_G_V;
                coef_mat[2][0] = C_ONE;
                coef_mat[2][1] = C_B_U;
                coef_mat[2][2] = '0;
            end
        endcase
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s2_prod_next[k][j] = prod_t'(s1_opnd_reg[j]) * prod_t'(coef_mat[k][j]);
            end
        end
    end

    // Stage 3: weighted sums, with the chroma offset in forward mode.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s3_sum_next[k] = sum_t'(s2_prod_reg[k][0]) + sum_t'(s2_prod_reg[k][1])
                           + sum_t'(s2_prod_reg[k][2]);
            if (s2_dir_reg == DIR_RGB_TO_YUV && k != 0)
                s3_sum_next[k] = s3_sum_next[k] + HALF_FIX;
        end
    end

    // Stage 4: floor, clip and put the components in output order.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            clip_val[k] = floor_clip(s3_sum_reg[k]);
        end
        s4_data_next.second_out = clip_val[1];
        s4_data_next.last_out   = s3_last_reg;
        if (s3_dir_reg == DIR_YUV_TO_RGB && s3_bf_reg)
        begin
            s4_data_next.first_out = clip_val[2];
            s4_data_next.third_out = clip_val[0];
        end
        else
        begin
            s4_data_next.first_out = clip_val[0];
            s4_data_next.third_out = clip_val[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= in_valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy4)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_opnd_reg <= s1_opnd_next;
            s1_dir_reg  <= direction_reg;
            s1_bf_reg   <= blue_first_reg;
            s1_last_reg <= in_data.last_pixel;
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_prod_reg <= s2_prod_next;
            s2_dir_reg  <= s1_dir_reg;
            s2_bf_reg   <= s1_bf_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_sum_reg  <= s3_sum_next;
            s3_dir_reg  <= s2_dir_reg;
            s3_bf_reg   <= s2_bf_reg;
            s3_last_reg <= s2_last_reg;
        end
        if (rdy4 && s3_valid_reg)
        begin
            s4_data_reg <= s4_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rycc_checker.sv =====
// Port-level checker for the colour space converter and its bind statement.
`default_nettype none

module rycc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire rycc_pkg::pixel_out_t              out_data,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready
);
    import rycc_pkg::*;

    // A held result must not change while the output side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // The input only stalls when every stage is full behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without back-pressure");

    // An item accepted while the output side does not stall comes out as a valid result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid)
        else $error("item lost in the pipeline");

    // Configuration writes are never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind rgb_yuv_color_space_converter_unit rycc_checker u_rycc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== dv/tb_rgb_yuv_color_space_converter_unit.sv =====
// Self-checking testbench for the RGB/YUV colour space converter unit.
`timescale 1ns / 1ps

module tb_rgb_yuv_color_space_converter_unit;

    import rycc_pkg::*;

    localparam int     FRAC_BITS      = rycc_pkg::FRACTION_BITS;
    localparam longint ONE_Q          = longint'(1) << FRAC_BITS;
    localparam longint HALF_Q         = longint'(128) << FRAC_BITS;
    localparam logic   ORDER_RGB      = 1'b0;
    localparam logic   ORDER_BGR      = 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int     NUM_ROWS       = 20;
    localparam int     NUM_PHASES     = 9;
    localparam int     PHASE_ITEMS    = 150;
    localparam int     HOLD_PHASE     = 2;
    localparam int     LONG_HOLD      = 300;
    localparam int     DRAIN_CYCLES   = 16;
    localparam int     WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic       dir;
        logic       bfirst;
        logic       typed;
        pixel_in_t  px;
        pixel_out_t want;
    } stim_row_t;

    // Rows with typed results are the black and white pixels whose outcome is plain.
    stim_row_t stim_rows [NUM_ROWS] = '{
        '{DIR_RGB_TO_YUV, ORDER_RGB, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0},
          '{8'd0,   8'd128, 8'd128, 1'b0}},
        '{DIR_RGB_TO_YUV, ORDER_RGB, 1'b0, '{8'd255, 8'd255, 8'd255, 1'b1}, '0},
        '{DIR_RGB_TO_YUV, ORDER_RGB, 1'b0, '{8'd255, 8'd0,   8'd0,   1'b0}, '0},
        '{DIR_RGB_TO_YUV, ORDER_RGB, 1'b0, '{8'd0,   8'd255, 8'd0,   1'b1}, '0},
        '{DIR_RGB_TO_YUV, ORDER_RGB, 1'b0, '{8'd0,   8'd0,   8'd255, 1'b0}, '0},
        '{DIR_RGB_TO_YUV, ORDER_RGB, 1'b0, '{8'd128, 8'd128, 8'd128, 1'b1}, '0},
        '{DIR_RGB_TO_YUV, ORDER_BGR, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1},
          '{8'd0,   8'd128, 8'd128, 1'b1}},
        '{DIR_RGB_TO_YUV, ORDER_BGR, 1'b0, '{8'd255, 8'd0,   8'd0,   1'b0}, '0},
        '{DIR_RGB_TO_YUV, ORDER_BGR, 1'b0, '{8'd0,   8'd0,   8'd255, 1'b1}, '0},
        '{DIR_YUV_TO_RGB, ORDER_RGB, 1'b1, '{8'd0,   8'd128, 8'd128, 1'b0},
          '{8'd0,   8'd0,   8'd0,   1'b0}},
        '{DIR_YUV_TO_RGB, ORDER_RGB, 1'b1, '{8'd255, 8'd128, 8'd128, 1'b1},
          '{8'd255, 8'd255, 8'd255, 1'b1}},
        '{DIR_YUV_TO_RGB, ORDER_RGB, 1'b0, '{8'd0,   8'd0,   8'd0,   1'b0}, '0},
        '{DIR_YUV_TO_RGB, ORDER_RGB, 1'b0, '{8'd255, 8'd255, 8'd255, 1'b1}, '0},
        '{DIR_YUV_TO_RGB, ORDER_RGB, 1'b0, '{8'd128, 8'd255, 8'd0,   1'b0}, '0},
        '{DIR_YUV_TO_RGB, ORDER_RGB, 1'b0, '{8'd128, 8'd0,   8'd255, 1'b1}, '0},
        '{DIR_YUV_TO_RGB, ORDER_BGR, 1'b1, '{8'd255, 8'd128, 8'd128, 1'b0},
          '{8'd255, 8'd255, 8'd255, 1'b0}},
        '{DIR_YUV_TO_RGB, ORDER_BGR, 1'b0, '{8'd128, 8'd255, 8'd0,   1'b1}, '0},
        '{DIR_YUV_TO_RGB, ORDER_BGR, 1'b0, '{8'd128, 8'd0,   8'd255, 1'b0}, '0},
        '{DIR_YUV_TO_RGB, ORDER_BGR, 1'b0, '{8'd60,  8'd200, 8'd40,  1'b1}, '0},
        '{DIR_RGB_TO_YUV, ORDER_RGB, 1'b0, '{8'd170, 8'd85,  8'd170, 1'b0}, '0}
    };

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    pixel_in_t              in_data     = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    pixel_out_t             out_data;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index   = REG_DIRECTION;
    logic                   cfg_data    = 1'b0;

    pixel_out_t expected_pixels [$];
    logic       cur_dir      = DIR_RGB_TO_YUV;
    logic       cur_bfirst   = ORDER_RGB;
    int         in_idle_pct  = 0;
    int         out_idle_pct = 0;
    logic       hold_active  = 1'b0;
    int         error_count  = 0;
    int         quiet_cycles = 0;
    event       long_hold_ev;

    rgb_yuv_color_space_converter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint fix_coef(input longint ten_thousandths);
        return (ten_thousandths * ONE_Q + 5000) / 10000;
    endfunction

    // The arithmetic shift of a signed sum rounds toward minus infinity.
    function automatic logic [7:0] floor_to_byte(input longint acc);
        longint whole;
        whole = acc >>> FRAC_BITS;
        if (whole < 0)
            return 8'd0;
        if (whole > 255)
            return 8'd255;
        return whole[7:0];
    endfunction

    function automatic pixel_out_t convert_pixel(input pixel_in_t px, input logic dir,
                                                 input logic bfirst);
        longint     a;
        longint     b;
        longint     c;
        longint     luma;
        logic [7:0] red;
        logic [7:0] blue;
        pixel_out_t res;
        a = longint'(px.first_in);
        b = longint'(px.second_in);
        c = longint'(px.third_in);
        if (dir == DIR_RGB_TO_YUV)
        begin
            res.first_out  = floor_to_byte(fix_coef(2990) * a + fix_coef(5870) * b
                                           + fix_coef(1140) * c);
            res.second_out = floor_to_byte(-fix_coef(1690) * a - fix_coef(3310) * b
                                           + fix_coef(4990) * c + HALF_Q);
            res.third_out  = floor_to_byte(fix_coef(4990) * a - fix_coef(4180) * b
                                           - fix_coef(813) * c + HALF_Q);
        end
        else
        begin
            luma = a * ONE_Q;
            b = b - 128;
            c = c - 128;
            red  = floor_to_byte(luma + fix_coef(14020) * c);
            blue = floor_to_byte(luma + fix_coef(17720) * b);
            res.first_out  = (bfirst == ORDER_BGR) ? blue : red;
            res.second_out = floor_to_byte(luma - fix_coef(3440) * b - fix_coef(7140) * c);
            res.third_out  = (bfirst == ORDER_BGR) ? red : blue;
        end
        res.last_out = px.last_pixel;
        return res;
    endfunction

    function automatic logic [7:0] pick_component();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(112, 144));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        error_count++;
        $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    // Leaves valid high after acceptance so that back-to-back items need no gap.
    task automatic send_pixel(input pixel_in_t px, input pixel_out_t want);
        if ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            in_data  <= pixel_in_t'($urandom);
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_pixels.push_back(want);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_DIRECTION:  cur_dir = value;
            REG_BLUE_FIRST: cur_bfirst = value;
            default: ;
        endcase
    endtask

    // A write to an unused index comes last, so any aliasing shows up in the results.
    task automatic program_config(input logic dir, input logic bfirst, input bit poke_spare);
        cfg_write(REG_DIRECTION, dir);
        cfg_write(REG_BLUE_FIRST, bfirst);
        if (poke_spare)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 1'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (expected_pixels.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        pixel_out_t want;
        int         stall_left;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("result with nothing expected, first_out", 0, out_data.first_out);
            else
            begin
                want = expected_pixels.pop_front();
                if (out_data.first_out !== want.first_out)
                    report_mismatch("first_out", want.first_out, out_data.first_out);
                if (out_data.second_out !== want.second_out)
                    report_mismatch("second_out", want.second_out, out_data.second_out);
                if (out_data.third_out !== want.third_out)
                    report_mismatch("third_out", want.third_out, out_data.third_out);
                if (out_data.last_out !== want.last_out)
                    report_mismatch("last_out", want.last_out, out_data.last_out);
            end
        end
        if (stall_left != 0)
            stall_left--;
        else if (rst_n && $urandom_range(0, 99) < out_idle_pct)
            stall_left = $urandom_range(1, 15);
        out_stall <= hold_active || (stall_left != 0);
    end

    // The long receiver hold-off runs on its own count while the sender keeps going.
    initial
    begin
        forever
        begin
            @(long_hold_ev);
            hold_active <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rgb_yuv_color_space_converter_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        pixel_in_t px;
        logic      ph_dir;
        logic      ph_bfirst;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; the first ones rely on the register values after reset.
        in_idle_pct  = 20;
        out_idle_pct <= 20;
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].dir != cur_dir || stim_rows[i].bfirst != cur_bfirst)
            begin
                in_valid <= 1'b0;
                wait_for_drain();
                program_config(stim_rows[i].dir, stim_rows[i].bfirst, 1'b0);
            end
            send_pixel(stim_rows[i].px, stim_rows[i].typed ? stim_rows[i].want
                       : convert_pixel(stim_rows[i].px, cur_dir, cur_bfirst));
        end
        in_valid <= 1'b0;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_drain();
            if (phase < 4)
            begin
                ph_dir    = phase[1];
                ph_bfirst = phase[0];
            end
            else
            begin
                ph_dir    = 1'($urandom);
                ph_bfirst = 1'($urandom);
            end
            program_config(ph_dir, ph_bfirst, 1'($urandom));
            if (phase == NUM_PHASES - 1)
            begin
                in_idle_pct  = 0;
                out_idle_pct <= 0;
            end
            else
            begin
                in_idle_pct  = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 8 : 30;
                out_idle_pct <= (phase % 3 == 2) ? 0 : (phase % 3 == 0) ? 10 : 30;
            end
            if (phase == HOLD_PHASE)
                -> long_hold_ev;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                px.first_in   = pick_component();
                px.second_in  = pick_component();
                px.third_in   = pick_component();
                px.last_pixel = 1'($urandom);
                send_pixel(px, convert_pixel(px, cur_dir, cur_bfirst));
            end
            in_valid <= 1'b0;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("rgb_yuv_color_space_converter_unit regression: pass");
        else
            $display("rgb_yuv_color_space_converter_unit regression: fail");
        $finish;
    end

endmodule
